@@ sv/kth_smallest_select_top_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the k-th smallest select block
// Clocked, reset-qualified concurrent assertion helpers.
// ---------------------------------------------------------------------------
`ifndef KTH_SMALLEST_SELECT_TOP_ASSERT_SVH
`define KTH_SMALLEST_SELECT_TOP_ASSERT_SVH

// Plain property, sampled on the block clock and ignored while in reset.
`define KSS_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define KSS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  `KSS_ASSERT_CLK(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define KSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  `KSS_ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

@@ sv/kss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kss_pkg
// Shared constants, types and sequencer states of the k-th smallest select.
// ---------------------------------------------------------------------------
package kss_pkg;

  localparam int unsigned MAX_ELEMENTS = 256;
  localparam int unsigned DATA_WIDTH   = 32;
  localparam int unsigned ADDR_WIDTH   = $clog2(MAX_ELEMENTS);
  localparam int unsigned COUNT_WIDTH  = ADDR_WIDTH + 1;
  localparam int unsigned RANK_WIDTH   = 9;
  localparam int unsigned LFSR_WIDTH   = 16;

  localparam logic [LFSR_WIDTH-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_WIDTH-1:0] LFSR_TAPS = 16'hB400;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [ADDR_WIDTH-1:0]        addr_t;
  typedef logic [COUNT_WIDTH-1:0]       count_t;
  typedef logic [RANK_WIDTH-1:0]        rank_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PICK,
    ST_PIVOT,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_EMIT
  } kss_state_e;

  // One write port of an element bank.
  typedef struct packed {
    logic  en;
    addr_t addr;
    data_t data;
  } wr_port_t;

  // Request to the pivot picker: current window and a step strobe.
  typedef struct packed {
    logic  step;
    addr_t lo;
    addr_t hi;
  } pick_req_t;

  // Sequencer status seen by the top level.
  typedef struct packed {
    logic   busy;
    logic   scanning;
    count_t placed;
    count_t span;
  } status_t;

endpackage
`default_nettype wire

@@ sv/kss_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kss_in_if / kss_out_if
// Valid/ready channels for element words and result words.
// ---------------------------------------------------------------------------
interface kss_in_if;
  logic                valid;
  logic                ready;
  kss_pkg::data_t      value;
  logic                last;
  kss_pkg::rank_t      rank;

  modport source (output valid, output value, output last, output rank, input ready);
  modport sink   (input valid, input value, input last, input rank, output ready);
endinterface

interface kss_out_if;
  logic                valid;
  logic                ready;
  kss_pkg::data_t      selected;
  logic                error;

  modport source (output valid, output selected, output error, input ready);
  modport sink   (input valid, input selected, input error, output ready);
endinterface
`default_nettype wire

@@ sv/kss_bank.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kss_bank
// One element bank: single write port, single registered read port.
// ---------------------------------------------------------------------------
module kss_bank (
  input  logic              clk_i,
  input  kss_pkg::wr_port_t wr_i,
  input  kss_pkg::addr_t    raddr_i,
  output kss_pkg::data_t    rdata_o
);

  kss_pkg::data_t mem_q [kss_pkg::MAX_ELEMENTS];
  kss_pkg::data_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/kss_pivot.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kss_pivot
// Pivot picker: a Galois LFSR folded into an offset inside the window.
// ---------------------------------------------------------------------------
module kss_pivot (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kss_pkg::pick_req_t req_i,
  output kss_pkg::addr_t     pick_o
);

  logic [kss_pkg::LFSR_WIDTH-1:0] lfsr_q, lfsr_d;
  kss_pkg::addr_t span_m1;
  kss_pkg::addr_t mask;
  kss_pkg::addr_t raw;
  kss_pkg::addr_t offset;

  always_comb begin
    lfsr_d = lfsr_q;
    if (req_i.step) begin
      lfsr_d = {1'b0, lfsr_q[kss_pkg::LFSR_WIDTH-1:1]} ^
               (lfsr_q[0] ? kss_pkg::LFSR_TAPS : '0);
    end
  end

  // The mask is the smallest all-ones value covering the window span, so the
  // masked draw is below twice the span and one subtract brings it inside.
  always_comb begin
    span_m1 = req_i.hi - req_i.lo;
    mask    = span_m1;
    for (int i = 1; i < int'(kss_pkg::ADDR_WIDTH); i = i * 2) begin
      mask = mask | (mask >> i);
    end
    raw = lfsr_q[kss_pkg::ADDR_WIDTH-1:0] & mask;
    if (raw > span_m1) begin
      offset = raw - span_m1 - kss_pkg::addr_t'(1);
    end else begin
      offset = raw;
    end
  end

  assign pick_o = req_i.lo + offset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= kss_pkg::LFSR_SEED;
    end else begin
      lfsr_q <= lfsr_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/kss_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kss_seq
// Load and selection sequencer: fills bank A, then partitions the window
// from one bank into the other each round and narrows toward the rank.
// ---------------------------------------------------------------------------
module kss_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  kss_in_if.sink             in_i,
  kss_out_if.source          out_o,
  output kss_pkg::wr_port_t  wr_a_o,
  output kss_pkg::wr_port_t  wr_b_o,
  output kss_pkg::addr_t     raddr_o,
  input  kss_pkg::data_t     rdata_a_i,
  input  kss_pkg::data_t     rdata_b_i,
  output kss_pkg::pick_req_t pick_req_o,
  input  kss_pkg::addr_t     pick_i,
  output kss_pkg::status_t   status_o
);

  kss_pkg::kss_state_e state_q, state_d;
  kss_pkg::count_t     count_q, count_d;
  kss_pkg::addr_t      lo_q, lo_d;
  kss_pkg::addr_t      hi_q, hi_d;
  kss_pkg::addr_t      target_q, target_d;
  logic                src_q, src_d;
  kss_pkg::addr_t      rd_idx_q, rd_idx_d;
  logic                rd_vld_q, rd_vld_d;
  kss_pkg::data_t      pivot_q, pivot_d;
  kss_pkg::count_t     n_lt_q, n_lt_d;
  kss_pkg::count_t     n_gt_q, n_gt_d;
  kss_pkg::data_t      res_sel_q, res_sel_d;
  logic                res_err_q, res_err_d;
  logic                out_valid_q, out_valid_d;
  kss_pkg::data_t      out_sel_q, out_sel_d;
  logic                out_err_q, out_err_d;

  logic            accept;
  logic            room;
  kss_pkg::count_t cnt_new;
  logic            rank_bad;
  kss_pkg::data_t  rd_data;
  logic            less;
  logic            greater;
  logic            scan_wen;
  kss_pkg::addr_t  scan_addr;
  kss_pkg::count_t lt_end;
  kss_pkg::count_t gt_start;
  kss_pkg::count_t tgt_ext;

  assign in_i.ready = (state_q == kss_pkg::ST_LOAD);
  assign accept     = in_i.valid && in_i.ready;
  assign room       = (count_q < kss_pkg::count_t'(kss_pkg::MAX_ELEMENTS));
  assign cnt_new    = count_q + (room ? kss_pkg::count_t'(1) : '0);
  assign rank_bad   = (in_i.rank == '0) || (in_i.rank > kss_pkg::rank_t'(cnt_new));

  // Words of the window: less goes to the low end, greater to the high end,
  // copies of the pivot are not written since their value is known.
  assign rd_data   = src_q ? rdata_b_i : rdata_a_i;
  assign less      = rd_data < pivot_q;
  assign greater   = rd_data > pivot_q;
  assign scan_wen  = rd_vld_q && (less || greater);
  assign scan_addr = less ? (lo_q + n_lt_q[kss_pkg::ADDR_WIDTH-1:0])
                          : (hi_q - n_gt_q[kss_pkg::ADDR_WIDTH-1:0]);

  assign lt_end   = {1'b0, lo_q} + n_lt_q;
  assign gt_start = {1'b0, hi_q} + kss_pkg::count_t'(1) - n_gt_q;
  assign tgt_ext  = {1'b0, target_q};

  always_comb begin
    wr_a_o = '0;
    wr_b_o = '0;
    if (state_q == kss_pkg::ST_LOAD) begin
      wr_a_o.en   = accept && room;
      wr_a_o.addr = count_q[kss_pkg::ADDR_WIDTH-1:0];
      wr_a_o.data = in_i.value;
    end else begin
      wr_a_o.en   = scan_wen && src_q;
      wr_a_o.addr = scan_addr;
      wr_a_o.data = rd_data;
      wr_b_o.en   = scan_wen && !src_q;
      wr_b_o.addr = scan_addr;
      wr_b_o.data = rd_data;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    target_d    = target_q;
    src_d       = src_q;
    rd_idx_d    = rd_idx_q;
    rd_vld_d    = 1'b0;
    pivot_d     = pivot_q;
    n_lt_d      = n_lt_q;
    n_gt_d      = n_gt_q;
    res_sel_d   = res_sel_q;
    res_err_d   = res_err_q;
    out_valid_d = out_valid_q;
    out_sel_d   = out_sel_q;
    out_err_d   = out_err_q;
    raddr_o     = rd_idx_q;
    pick_req_o  = '{step: 1'b0, lo: lo_q, hi: hi_q};

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (rd_vld_q) begin
      if (less) begin
        n_lt_d = n_lt_q + kss_pkg::count_t'(1);
      end else if (greater) begin
        n_gt_d = n_gt_q + kss_pkg::count_t'(1);
      end
    end

    case (state_q)
      kss_pkg::ST_LOAD: begin
        if (accept) begin
          if (in_i.last) begin
            count_d = '0;
            if (rank_bad) begin
              res_sel_d = '0;
              res_err_d = 1'b1;
              state_d   = kss_pkg::ST_EMIT;
            end else begin
              target_d = kss_pkg::addr_t'(in_i.rank - kss_pkg::rank_t'(1));
              lo_d     = '0;
              hi_d     = kss_pkg::addr_t'(cnt_new - kss_pkg::count_t'(1));
              src_d    = 1'b0;
              state_d  = kss_pkg::ST_PICK;
            end
          end else begin
            count_d = cnt_new;
          end
        end
      end
      kss_pkg::ST_PICK: begin
        raddr_o         = pick_i;
        pick_req_o.step = 1'b1;
        n_lt_d          = '0;
        n_gt_d          = '0;
        rd_idx_d        = lo_q;
        state_d         = kss_pkg::ST_PIVOT;
      end
      kss_pkg::ST_PIVOT: begin
        pivot_d = rd_data;
        state_d = kss_pkg::ST_SCAN;
      end
      kss_pkg::ST_SCAN: begin
        raddr_o  = rd_idx_q;
        rd_vld_d = 1'b1;
        rd_idx_d = rd_idx_q + kss_pkg::addr_t'(1);
        if (rd_idx_q == hi_q) begin
          state_d = kss_pkg::ST_DRAIN;
        end
      end
      kss_pkg::ST_DRAIN: begin
        state_d = kss_pkg::ST_DECIDE;
      end
      kss_pkg::ST_DECIDE: begin
        if (tgt_ext < lt_end) begin
          hi_d    = kss_pkg::addr_t'(lt_end - kss_pkg::count_t'(1));
          src_d   = !src_q;
          state_d = kss_pkg::ST_PICK;
        end else if (tgt_ext >= gt_start) begin
          lo_d    = gt_start[kss_pkg::ADDR_WIDTH-1:0];
          src_d   = !src_q;
          state_d = kss_pkg::ST_PICK;
        end else begin
          res_sel_d = pivot_q;
          res_err_d = 1'b0;
          state_d   = kss_pkg::ST_EMIT;
        end
      end
      kss_pkg::ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_sel_d   = res_sel_q;
          out_err_d   = res_err_q;
          state_d     = kss_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = kss_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kss_pkg::ST_LOAD;
      count_q     <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      target_q    <= '0;
      src_q       <= 1'b0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      pivot_q     <= '0;
      n_lt_q      <= '0;
      n_gt_q      <= '0;
      res_sel_q   <= '0;
      res_err_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_sel_q   <= '0;
      out_err_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      target_q    <= target_d;
      src_q       <= src_d;
      rd_idx_q    <= rd_idx_d;
      rd_vld_q    <= rd_vld_d;
      pivot_q     <= pivot_d;
      n_lt_q      <= n_lt_d;
      n_gt_q      <= n_gt_d;
      res_sel_q   <= res_sel_d;
      res_err_q   <= res_err_d;
      out_valid_q <= out_valid_d;
      out_sel_q   <= out_sel_d;
      out_err_q   <= out_err_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.selected = out_sel_q;
  assign out_o.error    = out_err_q;

  assign status_o.busy     = (state_q != kss_pkg::ST_LOAD);
  assign status_o.scanning = (state_q == kss_pkg::ST_SCAN) ||
                             (state_q == kss_pkg::ST_DRAIN) ||
                             (state_q == kss_pkg::ST_DECIDE);
  assign status_o.placed   = n_lt_q + n_gt_q;
  assign status_o.span     = {1'b0, hi_q} - {1'b0, lo_q} + kss_pkg::count_t'(1);

endmodule
`default_nettype wire

@@ sv/kth_smallest_select_top.sv @@
// The block takes one element word per cycle into bank A; the word with last
// set closes the set and carries the rank. Selection then runs in rounds:
// it reads a pivot picked by the LFSR, latches it, streams each element of
// the window through the read port and writes those below or above the
// pivot to the other bank on the low or high side, then finishes the round
// and narrows the window or, if the rank falls among the copies of the
// pivot, takes the pivot as the result. The single read port of each bank
// sets the pace of the scan. A bad rank skips the rounds and goes straight
// to the result with the error flag set. The result sits in an output
// register; new words are refused from the last word until the result has
// been loaded into it.
`timescale 1ns / 1ps
`default_nettype none
`include "kth_smallest_select_top_assert.svh"
// ---------------------------------------------------------------------------
// kth_smallest_select_top
// K-th smallest of a loaded set of signed words, by randomized quickselect.
// ---------------------------------------------------------------------------
module kth_smallest_select_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  kss_in_if.sink    in_i,
  kss_out_if.source out_o
);

  kss_pkg::wr_port_t  wr_a;
  kss_pkg::wr_port_t  wr_b;
  kss_pkg::addr_t     raddr;
  kss_pkg::data_t     rdata_a;
  kss_pkg::data_t     rdata_b;
  kss_pkg::pick_req_t pick_req;
  kss_pkg::addr_t     pick;
  kss_pkg::status_t   status;

  kss_bank u_bank_a (
    .clk_i   (clk_i),
    .wr_i    (wr_a),
    .raddr_i (raddr),
    .rdata_o (rdata_a)
  );

  kss_bank u_bank_b (
    .clk_i   (clk_i),
    .wr_i    (wr_b),
    .raddr_i (raddr),
    .rdata_o (rdata_b)
  );

  kss_pivot u_pivot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (pick_req),
    .pick_o (pick)
  );

  kss_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .wr_a_o     (wr_a),
    .wr_b_o     (wr_b),
    .raddr_o    (raddr),
    .rdata_a_i  (rdata_a),
    .rdata_b_i  (rdata_b),
    .pick_req_o (pick_req),
    .pick_i     (pick),
    .status_o   (status)
  );

  // Assertions.
  `KSS_ASSERT_IMPLY(a_busy_no_ready, status.busy, !in_i.ready, "input ready while selecting")
  `KSS_ASSERT_NEXT(a_last_starts, in_i.valid && in_i.ready && in_i.last, status.busy, "last word did not start selection")
  `KSS_ASSERT_IMPLY(a_err_zero, out_o.valid && out_o.error, out_o.selected == '0, "error word with nonzero value")
  `KSS_ASSERT_IMPLY(a_fill_in_window, status.scanning, status.placed <= status.span, "partition wrote past the window")

endmodule
`default_nettype wire
